### design/e2q_pkg.sv
`timescale 1ns / 1ps

package e2q_pkg;

    // Sine table depth (entries per quarter wave); must be a power of two.
    localparam int TRIG_TABLE_DEPTH = 256;
    localparam int DEPTH_W          = $clog2(TRIG_TABLE_DEPTH);
    localparam int ADDR_W           = DEPTH_W + 1;
    localparam int PHASE_W          = DEPTH_W + 2;

    // One full turn of the half angle, in 1/256 degree units (360 degrees).
    localparam int TURN_UNITS = 92160;
    localparam int TURN_W     = $clog2(TURN_UNITS);
    localparam int HALF_TURN  = TURN_UNITS / 2;

    // Rounding p * steps + half turn down to a phase step is done by an exact
    // reciprocal multiply: numerator below 2**NUM_W, shift NUM_W + TURN_W.
    localparam int NUM_W     = TURN_W + PHASE_W;
    localparam int DIV_SHIFT = NUM_W + TURN_W;
    localparam int RECIP_W   = NUM_W + 1;
    localparam int PROD_W    = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << DIV_SHIFT)
        + 64'(TURN_UNITS) - 64'd1) / 64'(TURN_UNITS));

    localparam int PAIR_W = 31;
    localparam int TRIP_W = 46;
    localparam int SUM_W  = TRIP_W + 1;

    localparam logic signed [15:0] Q15_MAX = 16'sd32767;
    localparam logic signed [15:0] Q15_MIN = -16'sd32767;

    localparam logic [7:0] MASK_RATE  = 8'hC3;
    localparam logic [7:0] MASK_ANGLE = 8'h47;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [14:0] sine_entry_t;
    typedef sine_entry_t sine_rom_t [0:TRIG_TABLE_DEPTH];

    typedef struct packed {
        logic [7:0]  mask;
        logic [15:0] turn_rate;
    } side_t;

    typedef struct packed {
        logic signed [TRIP_W-1:0] w_a;
        logic signed [TRIP_W-1:0] w_b;
        logic signed [TRIP_W-1:0] x_a;
        logic signed [TRIP_W-1:0] x_b;
        logic signed [TRIP_W-1:0] y_a;
        logic signed [TRIP_W-1:0] y_b;
        logic signed [TRIP_W-1:0] z_a;
        logic signed [TRIP_W-1:0] z_b;
    } trip_t;

    typedef struct packed {
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
        logic [15:0] w;
    } quat_t;

    // Quarter-wave sine table built at elaboration from a Q30 Taylor series.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       rom;
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned q15;
        int              k;
        int              n;
        for (k = 0; k <= TRIG_TABLE_DEPTH; k++) begin
            x = (HALF_PI_Q30 * 64'(k) + 64'(TRIG_TABLE_DEPTH / 2))
                / 64'(TRIG_TABLE_DEPTH);
            term = x;
            sum  = x;
            for (n = 1; n <= 8; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            q15 = (sum + 64'd16384) >> 15;
            if (q15 > 64'd32767) begin
                q15 = 64'd32767;
            end
            rom[k] = q15[14:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### design/euler_to_quaternion_setpoint_top.sv
`timescale 1ns / 1ps

// Channel  | Ports                 | tdata (low bit up)                   | tuser
// ---------+-----------------------+--------------------------------------+------------
// input    | s_tvalid/tready/tdata | roll, pitch, yaw angle, yaw_rate_in  | rate_mode
// result   | m_tvalid/tready/tdata | quat w, x, y, z, yaw_rate_out        | ignore_mask
//
// An accepted item moves to its result on the m_ side through the stage registers;
// one item is accepted per cycle unless all stages are full and stalled. Depth is
// set by the phase multiplier, sine ROM read, two product stages and rounding register.
// Reset (aresetn low at a clock edge) empties the pipeline; data registers are not
// cleared. A stall on m_tready holds each full stage, while empty stages ahead of
// it still fill, so s_tready only drops when every stage holds an item.
module euler_to_quaternion_setpoint_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // roll_angle, pitch_angle, yaw_angle, yaw_rate_in
    input  logic        s_tuser,   // rate_mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // quat_w, quat_x, quat_y, quat_z, yaw_rate_out
    output logic [7:0]  m_tuser    // ignore_mask
);

    // Stage 1: phase step, 2: sine/cosine ROM, 3: roll-pitch products,
    // 4: yaw products, 5: rounding and output register.
    logic [5:1]            valid_reg;
    logic [5:1]            stage_en;
    e2q_pkg::side_t        side_in;
    e2q_pkg::side_t        side_reg [1:5];

    logic [e2q_pkg::PHASE_W-1:0] phase_r;
    logic [e2q_pkg::PHASE_W-1:0] phase_p;
    logic [e2q_pkg::PHASE_W-1:0] phase_y;
    logic signed [15:0]          sin_r;
    logic signed [15:0]          cos_r;
    logic signed [15:0]          sin_p;
    logic signed [15:0]          cos_p;
    logic signed [15:0]          sin_y;
    logic signed [15:0]          cos_y;
    e2q_pkg::trip_t              trip;
    e2q_pkg::quat_t              quat;

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb begin
        stage_en[5] = !valid_reg[5] || m_tready;
        stage_en[4] = !valid_reg[4] || stage_en[5];
        stage_en[3] = !valid_reg[3] || stage_en[4];
        stage_en[2] = !valid_reg[2] || stage_en[3];
        stage_en[1] = !valid_reg[1] || stage_en[2];
    end

    assign s_tready = stage_en[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[1]) begin
                valid_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= 5; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // The mask and the passed-on yaw rate are settled at the input and simply
    // ride along with the item.
    always_comb begin
        side_in.mask      = s_tuser ? e2q_pkg::MASK_RATE : e2q_pkg::MASK_ANGLE;
        side_in.turn_rate = s_tuser ? s_tdata[63:48] : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            side_reg[1] <= side_in;
        end
        for (int k = 2; k <= 5; k++) begin
            if (stage_en[k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    e2q_phase u_phase_roll (
        .aclk     (aclk),
        .stage_en (stage_en[1]),
        .angle    (s_tdata[15:0]),
        .phase    (phase_r)
    );

    e2q_phase u_phase_pitch (
        .aclk     (aclk),
        .stage_en (stage_en[1]),
        .angle    (s_tdata[31:16]),
        .phase    (phase_p)
    );

    e2q_phase u_phase_yaw (
        .aclk     (aclk),
        .stage_en (stage_en[1]),
        .angle    (s_tdata[47:32]),
        .phase    (phase_y)
    );

    e2q_sincos u_sincos_roll (
        .aclk     (aclk),
        .stage_en (stage_en[2]),
        .phase    (phase_r),
        .sin_val  (sin_r),
        .cos_val  (cos_r)
    );

    e2q_sincos u_sincos_pitch (
        .aclk     (aclk),
        .stage_en (stage_en[2]),
        .phase    (phase_p),
        .sin_val  (sin_p),
        .cos_val  (cos_p)
    );

    e2q_sincos u_sincos_yaw (
        .aclk     (aclk),
        .stage_en (stage_en[2]),
        .phase    (phase_y),
        .sin_val  (sin_y),
        .cos_val  (cos_y)
    );

    e2q_quat_mul u_quat_mul (
        .aclk    (aclk),
        .pair_en (stage_en[3]),
        .trip_en (stage_en[4]),
        .sin_r   (sin_r),
        .cos_r   (cos_r),
        .sin_p   (sin_p),
        .cos_p   (cos_p),
        .sin_y   (sin_y),
        .cos_y   (cos_y),
        .trip    (trip)
    );

    e2q_round u_round (
        .aclk     (aclk),
        .stage_en (stage_en[5]),
        .trip     (trip),
        .quat     (quat)
    );

    assign m_tvalid = valid_reg[5];
    assign m_tdata  = {side_reg[5].turn_rate, quat};
    assign m_tuser  = side_reg[5].mask;

endmodule

### design/e2q_phase.sv
`timescale 1ns / 1ps

// Wraps an angle into one turn and rounds it to the nearest phase step.
module e2q_phase (
    input  logic                          aclk,
    input  logic                          stage_en,
    input  logic [15:0]                   angle,
    output logic [e2q_pkg::PHASE_W-1:0]   phase
);

    logic [e2q_pkg::TURN_W-1:0]  angle_ext;
    logic [e2q_pkg::TURN_W-1:0]  wrapped;
    logic [e2q_pkg::NUM_W-1:0]   numer;
    logic [e2q_pkg::PROD_W-1:0]  prod;
    logic [e2q_pkg::PHASE_W-1:0] phase_reg;
    logic [e2q_pkg::PHASE_W-1:0] phase_next;

    always_comb begin
        angle_ext = {{(e2q_pkg::TURN_W - 16){angle[15]}}, angle};
        // Negative angles get one turn added; the sum wraps back into range.
        wrapped = angle_ext + (angle[15] ? e2q_pkg::TURN_W'(e2q_pkg::TURN_UNITS)
                                         : '0);
        numer = {wrapped, {e2q_pkg::PHASE_W{1'b0}}}
              + e2q_pkg::NUM_W'(e2q_pkg::HALF_TURN);
        prod = e2q_pkg::PROD_W'(numer) * e2q_pkg::PROD_W'(e2q_pkg::RECIP);
        // Dropping the upper quotient bits takes the step modulo one turn.
        phase_next = prod[e2q_pkg::DIV_SHIFT +: e2q_pkg::PHASE_W];
    end

    always_ff @(posedge aclk) begin
        if (stage_en) begin
            phase_reg <= phase_next;
        end
    end

    assign phase = phase_reg;

endmodule

### design/e2q_sincos.sv
`timescale 1ns / 1ps

// Sine and cosine of a phase step by quadrant folding of the quarter-wave ROM.
module e2q_sincos (
    input  logic                          aclk,
    input  logic                          stage_en,
    input  logic [e2q_pkg::PHASE_W-1:0]   phase,
    output logic signed [15:0]            sin_val,
    output logic signed [15:0]            cos_val
);

    logic [1:0]                  quad;
    logic [e2q_pkg::DEPTH_W-1:0] frac;
    logic [e2q_pkg::ADDR_W-1:0]  fwd_addr;
    logic [e2q_pkg::ADDR_W-1:0]  rev_addr;
    logic [e2q_pkg::ADDR_W-1:0]  sin_addr;
    logic [e2q_pkg::ADDR_W-1:0]  cos_addr;
    logic [14:0]                 sin_mag_reg;
    logic [14:0]                 cos_mag_reg;
    logic                        sin_neg_reg;
    logic                        cos_neg_reg;

    always_comb begin
        quad     = phase[e2q_pkg::PHASE_W-1 -: 2];
        frac     = phase[e2q_pkg::DEPTH_W-1:0];
        fwd_addr = {1'b0, frac};
        rev_addr = e2q_pkg::ADDR_W'(e2q_pkg::TRIG_TABLE_DEPTH) - fwd_addr;
        sin_addr = quad[0] ? rev_addr : fwd_addr;
        // Cosine is the sine one quadrant further on.
        cos_addr = quad[0] ? fwd_addr : rev_addr;
    end

    always_ff @(posedge aclk) begin
        if (stage_en) begin
            sin_mag_reg <= e2q_pkg::SINE_ROM[sin_addr];
            cos_mag_reg <= e2q_pkg::SINE_ROM[cos_addr];
            sin_neg_reg <= quad[1];
            cos_neg_reg <= quad[1] ^ quad[0];
        end
    end

    assign sin_val = sin_neg_reg ? -$signed({1'b0, sin_mag_reg}) : $signed({1'b0, sin_mag_reg});
    assign cos_val = cos_neg_reg ? -$signed({1'b0, cos_mag_reg}) : $signed({1'b0, cos_mag_reg});

endmodule

### design/e2q_quat_mul.sv
`timescale 1ns / 1ps

// Roll-pitch pair products in one stage, then the yaw factor in the next.
module e2q_quat_mul (
    input  logic                  aclk,
    input  logic                  pair_en,
    input  logic                  trip_en,
    input  logic signed [15:0]    sin_r,
    input  logic signed [15:0]    cos_r,
    input  logic signed [15:0]    sin_p,
    input  logic signed [15:0]    cos_p,
    input  logic signed [15:0]    sin_y,
    input  logic signed [15:0]    cos_y,
    output e2q_pkg::trip_t        trip
);

    logic signed [e2q_pkg::PAIR_W-1:0] cc_reg;
    logic signed [e2q_pkg::PAIR_W-1:0] ss_reg;
    logic signed [e2q_pkg::PAIR_W-1:0] sc_reg;
    logic signed [e2q_pkg::PAIR_W-1:0] cs_reg;
    logic signed [15:0]                sin_y_reg;
    logic signed [15:0]                cos_y_reg;
    logic signed [31:0]                cc_full;
    logic signed [31:0]                ss_full;
    logic signed [31:0]                sc_full;
    logic signed [31:0]                cs_full;
    logic signed [e2q_pkg::SUM_W-1:0]  p_cc_cy;
    logic signed [e2q_pkg::SUM_W-1:0]  p_ss_sy;
    logic signed [e2q_pkg::SUM_W-1:0]  p_sc_cy;
    logic signed [e2q_pkg::SUM_W-1:0]  p_cs_sy;
    logic signed [e2q_pkg::SUM_W-1:0]  p_cs_cy;
    logic signed [e2q_pkg::SUM_W-1:0]  p_sc_sy;
    logic signed [e2q_pkg::SUM_W-1:0]  p_cc_sy;
    logic signed [e2q_pkg::SUM_W-1:0]  p_ss_cy;
    e2q_pkg::trip_t                    trip_reg;
    e2q_pkg::trip_t                    trip_next;

    always_comb begin
        cc_full = cos_r * cos_p;
        ss_full = sin_r * sin_p;
        sc_full = sin_r * cos_p;
        cs_full = cos_r * sin_p;
    end

    always_ff @(posedge aclk) begin
        if (pair_en) begin
            cc_reg    <= cc_full[e2q_pkg::PAIR_W-1:0];
            ss_reg    <= ss_full[e2q_pkg::PAIR_W-1:0];
            sc_reg    <= sc_full[e2q_pkg::PAIR_W-1:0];
            cs_reg    <= cs_full[e2q_pkg::PAIR_W-1:0];
            sin_y_reg <= sin_y;
            cos_y_reg <= cos_y;
        end
    end

    always_comb begin
        p_cc_cy = cc_reg * cos_y_reg;
        p_ss_sy = ss_reg * sin_y_reg;
        p_sc_cy = sc_reg * cos_y_reg;
        p_cs_sy = cs_reg * sin_y_reg;
        p_cs_cy = cs_reg * cos_y_reg;
        p_sc_sy = sc_reg * sin_y_reg;
        p_cc_sy = cc_reg * sin_y_reg;
        p_ss_cy = ss_reg * cos_y_reg;
        trip_next.w_a = p_cc_cy[e2q_pkg::TRIP_W-1:0];
        trip_next.w_b = p_ss_sy[e2q_pkg::TRIP_W-1:0];
        trip_next.x_a = p_sc_cy[e2q_pkg::TRIP_W-1:0];
        trip_next.x_b = p_cs_sy[e2q_pkg::TRIP_W-1:0];
        trip_next.y_a = p_cs_cy[e2q_pkg::TRIP_W-1:0];
        trip_next.y_b = p_sc_sy[e2q_pkg::TRIP_W-1:0];
        trip_next.z_a = p_cc_sy[e2q_pkg::TRIP_W-1:0];
        trip_next.z_b = p_ss_cy[e2q_pkg::TRIP_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (trip_en) begin
            trip_reg <= trip_next;
        end
    end

    assign trip = trip_reg;

endmodule

### design/e2q_round.sv
`timescale 1ns / 1ps

// Two-term sums rounded from Q45 to Q15 and clamped to the symmetric range.
module e2q_round (
    input  logic            aclk,
    input  logic            stage_en,
    input  e2q_pkg::trip_t  trip,
    output e2q_pkg::quat_t  quat
);

    e2q_pkg::quat_t quat_reg;
    e2q_pkg::quat_t quat_next;

    function automatic logic [15:0] to_q15(input logic signed [e2q_pkg::SUM_W-1:0] s);
        logic signed [e2q_pkg::SUM_W-1:0] t;
        logic signed [e2q_pkg::SUM_W-1:0] v;
        logic [15:0]                      r;
        t = s + (e2q_pkg::SUM_W'(1) <<< 29);
        v = t >>> 30;
        if (v > e2q_pkg::SUM_W'(e2q_pkg::Q15_MAX)) begin
            r = e2q_pkg::Q15_MAX;
        end else if (v < e2q_pkg::SUM_W'(e2q_pkg::Q15_MIN)) begin
            r = e2q_pkg::Q15_MIN;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    always_comb begin
        quat_next.w = to_q15(e2q_pkg::SUM_W'(trip.w_a) + e2q_pkg::SUM_W'(trip.w_b));
        quat_next.x = to_q15(e2q_pkg::SUM_W'(trip.x_a) - e2q_pkg::SUM_W'(trip.x_b));
        quat_next.y = to_q15(e2q_pkg::SUM_W'(trip.y_a) + e2q_pkg::SUM_W'(trip.y_b));
        quat_next.z = to_q15(e2q_pkg::SUM_W'(trip.z_a) - e2q_pkg::SUM_W'(trip.z_b));
    end

    always_ff @(posedge aclk) begin
        if (stage_en) begin
            quat_reg <= quat_next;
        end
    end

    assign quat = quat_reg;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int TBL_DEPTH    = e2q_pkg::TRIG_TABLE_DEPTH;
    localparam int PHASE_STEPS  = 4 * TBL_DEPTH;
    localparam longint TURN_256 = 92160;           // one turn in 1/256 degree units
    localparam longint unsigned HALF_PI_FIX = 64'd1686629713;   // pi/2 in Q30
    localparam longint Q15_LIM  = 32767;
    localparam int ANGLE_LIM    = 23040;           // 180 degrees in 1/128 degree units

    localparam int RANDOM_ITEMS = 1400;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               rate_mode;
        logic signed [15:0] turn_rate;
    } setpoint_t;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [7:0]         mask;
        logic signed [15:0] turn_rate;
    } attitude_t;

    // Directed rows. Where "typed" is set the expected attitude is written out;
    // the other rows are checked against the predictor.
    typedef struct packed {
        int roll;
        int pitch;
        int yaw;
        bit rate_mode;
        int turn_rate;
        bit typed;
        int w;
        int x;
        int y;
        int z;
        int mask;
        int yaw_rate_out;
    } stim_row_t;

    localparam int MR = int'(e2q_pkg::MASK_RATE);
    localparam int MA = int'(e2q_pkg::MASK_ANGLE);
    localparam int NUM_ROWS = 18;

    stim_row_t directed_rows [NUM_ROWS] = '{
        // All angles zero: identity quaternion; rate mode off zeroes the yaw rate.
        '{0, 0, 0, 1'b0, 4660, 1'b1, 32765, 0, 0, 0, MA, 0},
        '{0, 0, 0, 1'b1, 32767, 1'b1, 32765, 0, 0, 0, MR, 32767},
        '{0, 0, 0, 1'b1, -32768, 1'b1, 32765, 0, 0, 0, MR, -32768},
        // A half turn about a single axis puts the whole weight on that axis.
        '{ANGLE_LIM, 0, 0, 1'b0, 0, 1'b1, 0, 32765, 0, 0, MA, 0},
        '{-ANGLE_LIM, 0, 0, 1'b1, -1, 1'b1, 0, -32765, 0, 0, MR, -1},
        '{0, ANGLE_LIM, 0, 1'b0, 77, 1'b1, 0, 0, 32765, 0, MA, 0},
        '{0, -ANGLE_LIM, 0, 1'b1, 1, 1'b1, 0, 0, -32765, 0, MR, 1},
        '{0, 0, ANGLE_LIM, 1'b0, -5, 1'b1, 0, 0, 0, 32765, MA, 0},
        '{0, 0, -ANGLE_LIM, 1'b1, 256, 1'b1, 0, 0, 0, -32765, MR, 256},
        '{ANGLE_LIM, ANGLE_LIM, ANGLE_LIM, 1'b1, -1, 1'b0, 0, 0, 0, 0, 0, 0},
        '{-ANGLE_LIM, -ANGLE_LIM, -ANGLE_LIM, 1'b0, 32767, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ANGLE_LIM, -ANGLE_LIM, ANGLE_LIM, 1'b0, -32768, 1'b0, 0, 0, 0, 0, 0, 0},
        '{1, -1, 2, 1'b1, 12345, 1'b0, 0, 0, 0, 0, 0, 0},
        // In the first row below, phase rounding ties land exactly halfway between two table steps.
        '{45, -45, 135, 1'b1, 1, 1'b0, 0, 0, 0, 0, 0, 0},
        '{-1, -1, -1, 1'b1, -32768, 1'b0, 0, 0, 0, 0, 0, 0},
        '{11520, -11520, 5760, 1'b0, -1000, 1'b0, 0, 0, 0, 0, 0, 0},
        '{5760, 5760, 5760, 1'b1, 21845, 1'b0, 0, 0, 0, 0, 0, 0},
        '{-11520, 17280, -17280, 1'b1, -21846, 1'b0, 0, 0, 0, 0, 0, 0}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [7:0]  m_tuser;

    longint unsigned sine_q15 [0:TBL_DEPTH];
    attitude_t       pending_attitudes [$];
    attitude_t       oldest_attitude;
    int              errors = 0;
    int              items_sent = 0;
    int              idle_cycles = 0;
    bit              steady_sender = 1'b0;
    bit              long_hold_done = 1'b0;

    euler_to_quaternion_setpoint_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Half angle in table steps: the raw 1/128 degree angle read as 1/256 degree
    // units, wrapped into one turn and rounded to the nearest step, ties up.
    function automatic int phase_index(logic signed [15:0] raw);
        longint p;
        p = (raw < 0) ? longint'(raw) + TURN_256 : longint'(raw);
        return int'(((p * PHASE_STEPS + TURN_256 / 2) / TURN_256) % PHASE_STEPS);
    endfunction

    function automatic longint sine_of(int idx);
        int     wrapped;
        int     quad;
        int     offs;
        longint mag;
        wrapped = idx % PHASE_STEPS;
        quad    = wrapped / TBL_DEPTH;
        offs    = wrapped % TBL_DEPTH;
        mag = (quad % 2 == 1) ? longint'(sine_q15[TBL_DEPTH - offs])
                              : longint'(sine_q15[offs]);
        return (quad >= 2) ? -mag : mag;
    endfunction

    // Q45 sum to Q15: add half an LSB, floor, then clamp symmetrically.
    function automatic logic signed [15:0] round_q15(longint acc);
        longint v;
        v = (acc + (longint'(1) <<< 29)) >>> 30;
        if (v > Q15_LIM) begin
            v = Q15_LIM;
        end else if (v < -Q15_LIM) begin
            v = -Q15_LIM;
        end
        return 16'(v);
    endfunction

    function automatic attitude_t euler_to_quat(setpoint_t cmd);
        attitude_t att;
        longint    sin_r, cos_r, sin_p, cos_p, sin_y, cos_y;
        int        ir, ip, iy;
        ir    = phase_index(cmd.roll);
        ip    = phase_index(cmd.pitch);
        iy    = phase_index(cmd.yaw);
        sin_r = sine_of(ir);
        cos_r = sine_of(ir + TBL_DEPTH);
        sin_p = sine_of(ip);
        cos_p = sine_of(ip + TBL_DEPTH);
        sin_y = sine_of(iy);
        cos_y = sine_of(iy + TBL_DEPTH);
        att.w = round_q15(cos_r * cos_p * cos_y + sin_r * sin_p * sin_y);
        att.x = round_q15(sin_r * cos_p * cos_y - cos_r * sin_p * sin_y);
        att.y = round_q15(cos_r * sin_p * cos_y + sin_r * cos_p * sin_y);
        att.z = round_q15(cos_r * cos_p * sin_y - sin_r * sin_p * cos_y);
        att.mask      = cmd.rate_mode ? e2q_pkg::MASK_RATE : e2q_pkg::MASK_ANGLE;
        att.turn_rate = cmd.rate_mode ? cmd.turn_rate : 16'sd0;
        return att;
    endfunction

    // Mostly uniform over the legal range, with the extremes and small angles
    // near zero drawn more often.
    function automatic logic signed [15:0] random_angle();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return $urandom_range(0, 1) ? 16'(ANGLE_LIM) : 16'(-ANGLE_LIM);
        end
        if (pick == 1) begin
            return 16'(int'($urandom_range(0, 512)) - 256);
        end
        return 16'(int'($urandom_range(0, 2 * ANGLE_LIM)) - ANGLE_LIM);
    endfunction

    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady_sender || pick < 70) begin
            return 0;
        end
        if (pick < 96) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(string label, int expected, int actual);
        if (expected != actual) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, label, expected, actual);
            errors++;
        end
    endfunction

    task automatic send_setpoint(setpoint_t cmd, attitude_t want);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cmd.turn_rate, cmd.yaw, cmd.pitch, cmd.roll};
        s_tuser  <= cmd.rate_mode;
        do @(posedge aclk); while (!s_tready);
        pending_attitudes.push_back(want);
        items_sent++;
    endtask

    // Result checker: every accepted item is compared with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_attitudes.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got tdata=%h tuser=%h",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                oldest_attitude = pending_attitudes.pop_front();
                check_field("quat_w", oldest_attitude.w, $signed(m_tdata[15:0]));
                check_field("quat_x", oldest_attitude.x, $signed(m_tdata[31:16]));
                check_field("quat_y", oldest_attitude.y, $signed(m_tdata[47:32]));
                check_field("quat_z", oldest_attitude.z, $signed(m_tdata[63:48]));
                check_field("yaw_rate_out", oldest_attitude.turn_rate,
                            $signed(m_tdata[79:64]));
                check_field("ignore_mask", oldest_attitude.mask, m_tuser);
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("euler_to_quaternion_setpoint_top verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Receiver: random back-pressure, with one long hold-off that fills the
    // pipeline and forces s_tready low while items keep being offered.
    initial begin : receiver
        int pick;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!long_hold_done && items_sent >= 300) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(1, 12)) @(posedge aclk);
                end else if (pick < 70) begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(50, 120)) @(posedge aclk);
                end else if (pick < 96) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(8, 40)) @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        longint unsigned x_q30;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned q15;
        setpoint_t       cmd;
        attitude_t       want;
        stim_row_t       row;
        int              k;
        int              n;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;

        // Quarter-wave sine table from a Q30 Taylor series up to x^17.
        for (k = 0; k <= TBL_DEPTH; k++) begin
            x_q30 = (HALF_PI_FIX * longint'(k) + longint'(TBL_DEPTH / 2))
                    / longint'(TBL_DEPTH);
            term = x_q30;
            acc  = x_q30;
            for (n = 1; n <= 8; n++) begin
                term = (term * x_q30) >> 30;
                term = (term * x_q30) >> 30;
                term = term / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = (acc >= term) ? acc - term : 64'd0;
                end else begin
                    acc = acc + term;
                end
            end
            q15 = (acc + 64'd16384) >> 15;
            sine_q15[k] = (q15 > Q15_LIM) ? Q15_LIM : q15;
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < NUM_ROWS; k++) begin
            row = directed_rows[k];
            cmd.roll      = 16'(row.roll);
            cmd.pitch     = 16'(row.pitch);
            cmd.yaw       = 16'(row.yaw);
            cmd.rate_mode = row.rate_mode;
            cmd.turn_rate = 16'(row.turn_rate);
            if (row.typed) begin
                want.w         = 16'(row.w);
                want.x         = 16'(row.x);
                want.y         = 16'(row.y);
                want.z         = 16'(row.z);
                want.mask      = 8'(row.mask);
                want.turn_rate = 16'(row.yaw_rate_out);
            end else begin
                want = euler_to_quat(cmd);
            end
            send_setpoint(cmd, want);
        end

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            // Some stretches run with the sender never pausing.
            steady_sender = (k % 256) < 40;
            cmd.roll      = random_angle();
            cmd.pitch     = random_angle();
            cmd.yaw       = random_angle();
            cmd.rate_mode = 1'($urandom_range(0, 1));
            cmd.turn_rate = 16'($urandom);
            send_setpoint(cmd, euler_to_quat(cmd));
        end
        s_tvalid <= 1'b0;

        while (pending_attitudes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("euler_to_quaternion_setpoint_top verification clean");
        end else begin
            $display("euler_to_quaternion_setpoint_top verification failed");
        end
        $finish;
    end

endmodule
